### src/flbm_pkg.sv
// ----------------------------------------------------------------------------
// Frame latency and bitrate monitor package
// Shared widths, event codes, register indexes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package flbm_pkg;

	// Default number of entries in the timestamp ring.
	localparam int RING_DEPTH_DEF = 16;

	// Field widths.
	localparam int OPCODE_W = 2;
	localparam int PTS_W    = 64;
	localparam int NS_W     = 63;
	localparam int BYTES_W  = 29;
	localparam int BITS_W   = 32;
	localparam int EVENTS_W = 32;
	localparam int USEC_W   = 63;

	// The average is sum / (events * 1000); the divisor fits in 42 bits.
	localparam int DIVISOR_W = 42;
	localparam int DIV_STEPS = NS_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_BITRATE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PTS_REGISTER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_LATENCY      = 2'd2;

	// Event codes.
	localparam logic [OPCODE_W-1:0] OP_IN_FRAME   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_OUT_FRAME  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_OUT_PTS    = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_TICK       = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;          // capture the input beat
		logic frame_update;  // ring write and bit counting for frame events
		logic search_init;   // start the ring search at the write index
		logic search_read;   // read the ring entry under the search index
		logic search_next;   // advance the search index
		logic accumulate;    // add the delay of the hit entry
		logic tick_bits;     // publish and clear the bit counters
		logic div_init;      // load the divider, clear the latency sum
		logic div_step;      // one quotient bit
		logic div_finish;    // publish average, peak and floor
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic                pts_positive;
		logic                en_latency;
		logic                hit;
		logic                search_last;
		logic                div_last;
	} status_t;

endpackage

`default_nettype wire

### src/frame_latency_bitrate_monitor_core.sv
// Sequencing: an output timestamp is searched one ring entry at a time, up to
// RING_DEPTH entries, through the single ring read port; a period tick with
// latency enabled runs the 63-step bit-serial divider before done.
// Throughput: one event at a time; the next start is taken the cycle after done.
// Reset clears configuration, counters, statistics and ring valid bits at once.
// ----------------------------------------------------------------------------
// Frame latency and bitrate monitor
// Top level: controller and datapath for per-period bitrate and latency
// statistics over input, output and tick events.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_latency_bitrate_monitor_core #(
	parameter int RING_DEPTH = flbm_pkg::RING_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [flbm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [flbm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [flbm_pkg::OPCODE_W-1:0]       opcode,
	input  wire logic signed [flbm_pkg::PTS_W-1:0]   pts,
	input  wire logic [flbm_pkg::NS_W-1:0]           now_ns,
	input  wire logic [flbm_pkg::BYTES_W-1:0]        frame_bytes,
	output logic                                     done,
	output logic                                     matched,
	output logic [flbm_pkg::BITS_W-1:0]              bitrate_in,
	output logic [flbm_pkg::BITS_W-1:0]              bitrate_out,
	output logic [flbm_pkg::USEC_W-1:0]              lat_avg_us,
	output logic [flbm_pkg::USEC_W-1:0]              lat_max_us,
	output logic [flbm_pkg::USEC_W-1:0]              lat_min_us
);

	flbm_pkg::cmd_t    cmd;
	flbm_pkg::status_t status;

	// Sequencer.
	flbm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Storage and arithmetic.
	flbm_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.opcode      (opcode),
		.pts         (pts),
		.now_ns      (now_ns),
		.frame_bytes (frame_bytes),
		.cmd         (cmd),
		.status      (status),
		.matched     (matched),
		.bitrate_in  (bitrate_in),
		.bitrate_out (bitrate_out),
		.lat_avg_us  (lat_avg_us),
		.lat_max_us  (lat_max_us),
		.lat_min_us  (lat_min_us)
	);

endmodule

`default_nettype wire

### src/flbm_ctrl.sv
// ----------------------------------------------------------------------------
// Frame latency and bitrate monitor controller
// Sequences one event at a time: dispatch, ring search, period division,
// and the one-cycle result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module flbm_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire flbm_pkg::status_t  status,
	output flbm_pkg::cmd_t          cmd,
	output logic                    busy,
	output logic                    done
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DISPATCH = 7'b0000010,
		S_SRD      = 7'b0000100,
		S_SCMP     = 7'b0001000,
		S_DIV      = 7'b0010000,
		S_FIN      = 7'b0100000,
		S_DONE     = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Next state and command decode.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (status.opcode) inside
					flbm_pkg::OP_IN_FRAME, flbm_pkg::OP_OUT_FRAME: begin
						cmd.frame_update = 1'b1;
						state_nxt        = S_DONE;
					end
					flbm_pkg::OP_OUT_PTS: begin
						if (status.pts_positive) begin
							cmd.search_init = 1'b1;
							state_nxt       = S_SRD;
						end else begin
							state_nxt = S_DONE;
						end
					end
					flbm_pkg::OP_TICK: begin
						cmd.tick_bits = 1'b1;
						if (status.en_latency) begin
							cmd.div_init = 1'b1;
							state_nxt    = S_DIV;
						end else begin
							state_nxt = S_DONE;
						end
					end
					default: state_nxt = S_DONE;
				endcase
			end
			S_SRD: begin
				cmd.search_read = 1'b1;
				state_nxt       = S_SCMP;
			end
			S_SCMP: begin
				if (status.hit) begin
					cmd.accumulate = 1'b1;
					state_nxt      = S_DONE;
				end else if (status.search_last) begin
					state_nxt = S_DONE;
				end else begin
					cmd.search_next = 1'b1;
					state_nxt       = S_SRD;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				cmd.div_finish = 1'b1;
				state_nxt      = S_DONE;
			end
			S_DONE: begin
				state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

`default_nettype wire

### src/flbm_datapath.sv
// ----------------------------------------------------------------------------
// Frame latency and bitrate monitor datapath
// Holds the configuration, the timestamp ring, the bit and latency
// accumulators, a bit-serial divider and the published statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module flbm_datapath #(
	parameter int RING_DEPTH = flbm_pkg::RING_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [flbm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [flbm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic [flbm_pkg::OPCODE_W-1:0]       opcode,
	input  wire logic signed [flbm_pkg::PTS_W-1:0]   pts,
	input  wire logic [flbm_pkg::NS_W-1:0]           now_ns,
	input  wire logic [flbm_pkg::BYTES_W-1:0]        frame_bytes,
	input  wire flbm_pkg::cmd_t                      cmd,
	output flbm_pkg::status_t                        status,
	output logic                                     matched,
	output logic [flbm_pkg::BITS_W-1:0]              bitrate_in,
	output logic [flbm_pkg::BITS_W-1:0]              bitrate_out,
	output logic [flbm_pkg::USEC_W-1:0]              lat_avg_us,
	output logic [flbm_pkg::USEC_W-1:0]              lat_max_us,
	output logic [flbm_pkg::USEC_W-1:0]              lat_min_us
);

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

	// Configuration.
	logic en_bitrate_q;
	logic en_pts_q;
	logic en_latency_q;

	// Captured input beat.
	logic [flbm_pkg::OPCODE_W-1:0] opcode_q;
	logic [flbm_pkg::PTS_W-1:0]    pts_q;
	logic [flbm_pkg::NS_W-1:0]     now_q;
	logic [flbm_pkg::BYTES_W-1:0]  bytes_q;

	// Ring storage; entries that were never written read as no match.
	logic [flbm_pkg::PTS_W-1:0] pts_mem   [RING_DEPTH];
	logic [flbm_pkg::NS_W-1:0]  stamp_mem [RING_DEPTH];
	logic [RING_DEPTH-1:0]      ring_valid_q;
	logic [flbm_pkg::PTS_W-1:0] rd_pts_q;
	logic [flbm_pkg::NS_W-1:0]  rd_stamp_q;
	logic                       rd_valid_q;
	logic [IDX_W-1:0]           wr_idx_q;
	logic [IDX_W-1:0]           srch_idx_q;
	logic [IDX_W-1:0]           srch_cnt_q;

	// Accumulators and published values.
	logic [flbm_pkg::BITS_W-1:0]   in_bits_q;
	logic [flbm_pkg::BITS_W-1:0]   out_bits_q;
	logic [flbm_pkg::NS_W-1:0]     lat_sum_q;
	logic [flbm_pkg::EVENTS_W-1:0] lat_events_q;
	logic                          matched_q;
	logic [flbm_pkg::BITS_W-1:0]   last_in_q;
	logic [flbm_pkg::BITS_W-1:0]   last_out_q;
	logic [flbm_pkg::USEC_W-1:0]   last_avg_q;
	logic [flbm_pkg::USEC_W-1:0]   peak_q;
	logic [flbm_pkg::USEC_W-1:0]   floor_q;

	// Divider.
	logic [flbm_pkg::NS_W-1:0]      quo_q;
	logic [flbm_pkg::DIVISOR_W-1:0] rem_q;
	logic [flbm_pkg::DIVISOR_W-1:0] divisor_q;
	logic [flbm_pkg::DIV_CNT_W-1:0] div_cnt_q;

	// Combinational helpers.
	logic                            ring_write;
	logic [flbm_pkg::BITS_W-1:0]     frame_bits;
	logic                            hit;
	logic                            delay_pos;
	logic [flbm_pkg::NS_W-1:0]       delay;
	logic [flbm_pkg::NS_W:0]         sum_wide;
	logic [flbm_pkg::DIVISOR_W-1:0]  ev_x1000;
	logic [flbm_pkg::DIVISOR_W:0]    trial;
	logic                            trial_ge;
	logic [flbm_pkg::DIVISOR_W-1:0]  trial_diff;

	assign ring_write = cmd.frame_update && (opcode_q == flbm_pkg::OP_IN_FRAME)
		&& en_pts_q && en_latency_q;
	assign frame_bits = {bytes_q, 3'b000};

	// A hit needs a written entry with an equal timestamp.
	assign hit       = rd_valid_q && (rd_pts_q == pts_q);
	assign delay_pos = (now_q > rd_stamp_q);
	assign delay     = now_q - rd_stamp_q;
	assign sum_wide  = {1'b0, lat_sum_q} + {1'b0, delay};

	// events * 1000 as events * 1024 - events * 16 - events * 8.
	assign ev_x1000 = ({lat_events_q, 10'b0})
		- flbm_pkg::DIVISOR_W'({lat_events_q, 4'b0})
		- flbm_pkg::DIVISOR_W'({lat_events_q, 3'b0});

	// One restoring division step; the difference is only kept when it fits.
	assign trial      = {rem_q, quo_q[flbm_pkg::NS_W-1]};
	assign trial_ge   = (trial >= {1'b0, divisor_q});
	assign trial_diff = flbm_pkg::DIVISOR_W'(trial - {1'b0, divisor_q});

	// Status toward the controller.
	always_comb begin
		status              = '0;
		status.opcode       = opcode_q;
		status.pts_positive = !pts_q[flbm_pkg::PTS_W-1] && (|pts_q[flbm_pkg::PTS_W-2:0]);
		status.en_latency   = en_latency_q;
		status.hit          = hit;
		status.search_last  = (srch_cnt_q == IDX_LAST);
		status.div_last     = (div_cnt_q == flbm_pkg::DIV_CNT_W'(flbm_pkg::DIV_STEPS - 1));
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opcode_q <= opcode;
			pts_q    <= pts;
			now_q    <= now_ns;
			bytes_q  <= frame_bytes;
		end
	end

	// Ring memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (ring_write) begin
			pts_mem[wr_idx_q]   <= pts_q;
			stamp_mem[wr_idx_q] <= now_q;
		end
		if (cmd.search_read) begin
			rd_pts_q   <= pts_mem[srch_idx_q];
			rd_stamp_q <= stamp_mem[srch_idx_q];
		end
	end

	// Divider datapath.
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			if (lat_events_q == '0) begin
				quo_q     <= '0;
				divisor_q <= flbm_pkg::DIVISOR_W'(1);
			end else begin
				quo_q     <= lat_sum_q;
				divisor_q <= ev_x1000;
			end
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_diff : trial[flbm_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[flbm_pkg::NS_W-2:0], trial_ge};
		end
	end

	// Configuration, ring control, accumulators and statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_bitrate_q <= 1'b0;
			en_pts_q     <= 1'b0;
			en_latency_q <= 1'b0;
			ring_valid_q <= '0;
			rd_valid_q   <= 1'b0;
			wr_idx_q     <= '0;
			srch_idx_q   <= '0;
			srch_cnt_q   <= '0;
			div_cnt_q    <= '0;
			in_bits_q    <= '0;
			out_bits_q   <= '0;
			lat_sum_q    <= '0;
			lat_events_q <= '0;
			matched_q    <= 1'b0;
			last_in_q    <= '0;
			last_out_q   <= '0;
			last_avg_q   <= '0;
			peak_q       <= '0;
			floor_q      <= '0;
		end else begin
			// Register writes; unknown indexes are dropped.
			if (cfg_we) begin
				unique case (cfg_index)
					flbm_pkg::CFG_ENABLE_BITRATE:      en_bitrate_q <= cfg_data[0];
					flbm_pkg::CFG_ENABLE_PTS_REGISTER: en_pts_q     <= cfg_data[0];
					flbm_pkg::CFG_ENABLE_LATENCY:      en_latency_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (cmd.load) begin
				matched_q <= 1'b0;
			end

			// Frame events.
			if (ring_write) begin
				ring_valid_q[wr_idx_q] <= 1'b1;
				wr_idx_q <= (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + 1'b1;
			end
			if (cmd.frame_update && en_bitrate_q) begin
				if (opcode_q == flbm_pkg::OP_IN_FRAME) begin
					in_bits_q <= in_bits_q + frame_bits;
				end else begin
					out_bits_q <= out_bits_q + frame_bits;
				end
			end

			// Ring search walks forward from the write index.
			if (cmd.search_init) begin
				srch_idx_q <= wr_idx_q;
				srch_cnt_q <= '0;
			end else if (cmd.search_next) begin
				srch_idx_q <= (srch_idx_q == IDX_LAST) ? '0 : srch_idx_q + 1'b1;
				srch_cnt_q <= srch_cnt_q + 1'b1;
			end
			if (cmd.search_read) begin
				rd_valid_q <= ring_valid_q[srch_idx_q];
			end

			// A hit with a positive delay adds to the saturating sum.
			if (cmd.accumulate && delay_pos) begin
				matched_q <= 1'b1;
				lat_sum_q <= sum_wide[flbm_pkg::NS_W] ? '1 : sum_wide[flbm_pkg::NS_W-1:0];
				if (lat_events_q != '1) begin
					lat_events_q <= lat_events_q + 1'b1;
				end
			end

			// Period tick: bit counters.
			if (cmd.tick_bits && en_bitrate_q) begin
				last_in_q  <= in_bits_q;
				last_out_q <= out_bits_q;
				in_bits_q  <= '0;
				out_bits_q <= '0;
			end

			// Period tick: latency.
			if (cmd.div_init) begin
				lat_sum_q    <= '0;
				lat_events_q <= '0;
				div_cnt_q    <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.div_finish) begin
				last_avg_q <= quo_q;
				if (quo_q > peak_q) begin
					peak_q <= quo_q;
				end
				if ((floor_q == '0) || ((quo_q != '0) && (quo_q < floor_q))) begin
					floor_q <= quo_q;
				end
			end
		end
	end

	assign matched     = matched_q;
	assign bitrate_in  = last_in_q;
	assign bitrate_out = last_out_q;
	assign lat_avg_us  = last_avg_q;
	assign lat_max_us  = peak_q;
	assign lat_min_us  = floor_q;

endmodule

`default_nettype wire

### src/flbm_checker.sv
// ----------------------------------------------------------------------------
// Frame latency and bitrate monitor checker
// Port-level checks on the start, busy and done sequencing, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module flbm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// A result beat only appears while an event is in progress.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done strobe while idle");

	// An accepted event makes the block busy on the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted event did not raise busy");

	// After the result beat the block is ready again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy held after result beat");

	// Busy only drops right after a result beat.
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("event ended without a result beat");

	// An idle block with no start stays idle.
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !busy)
		else $error("busy raised without start");

endmodule

bind frame_latency_bitrate_monitor_core flbm_checker u_flbm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire

### verif/frame_latency_bitrate_monitor_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame latency and bitrate monitor testbench
// Drives input frame, output frame, output timestamp and period tick events
// into the monitor. Each beat is run through a local model of the counters,
// the timestamp ring and the latency statistics. Every done strobe is checked
// field by field against the oldest prediction. A directed part covers the
// field extremes and the corner cases. Random traffic follows under several
// enable settings and sender idle rates.
// ----------------------------------------------------------------------------

module frame_latency_bitrate_monitor_core_tb;

	localparam int          RING_N   = flbm_pkg::RING_DEPTH_DEF;
	localparam logic [63:0] NSEC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	// One published status beat as it appears on the result ports.
	typedef struct packed {
		logic                        matched;
		logic [flbm_pkg::BITS_W-1:0] bits_in;
		logic [flbm_pkg::BITS_W-1:0] bits_out;
		logic [flbm_pkg::USEC_W-1:0] avg_usec;
		logic [flbm_pkg::USEC_W-1:0] max_usec;
		logic [flbm_pkg::USEC_W-1:0] min_usec;
	} stats_t;

	// Block ports.
	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            cfg_we      = 1'b0;
	logic [flbm_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [flbm_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
	logic                            start       = 1'b0;
	logic [flbm_pkg::OPCODE_W-1:0]   opcode      = flbm_pkg::OP_TICK;
	logic [flbm_pkg::PTS_W-1:0]      pts         = '0;
	logic [flbm_pkg::NS_W-1:0]       now_ns      = '0;
	logic [flbm_pkg::BYTES_W-1:0]    frame_bytes = '0;
	logic                            busy;
	logic                            done;
	logic                            matched;
	logic [flbm_pkg::BITS_W-1:0]     bitrate_in;
	logic [flbm_pkg::BITS_W-1:0]     bitrate_out;
	logic [flbm_pkg::USEC_W-1:0]     lat_avg_us;
	logic [flbm_pkg::USEC_W-1:0]     lat_max_us;
	logic [flbm_pkg::USEC_W-1:0]     lat_min_us;

	// Local copy of the monitor state and its enables.
	logic                          en_bits = 1'b0;
	logic                          en_ring = 1'b0;
	logic                          en_lat  = 1'b0;
	logic [63:0]                   ring_pts   [RING_N] = '{default: '1};
	logic [63:0]                   ring_stamp [RING_N] = '{default: '1};
	int unsigned                   wr_ptr      = 0;
	logic [flbm_pkg::BITS_W-1:0]   in_bits     = '0;
	logic [flbm_pkg::BITS_W-1:0]   out_bits    = '0;
	logic [63:0]                   lat_sum     = '0;
	logic [flbm_pkg::EVENTS_W-1:0] lat_cnt     = '0;
	logic [flbm_pkg::BITS_W-1:0]   pub_in      = '0;
	logic [flbm_pkg::BITS_W-1:0]   pub_out     = '0;
	logic [63:0]                   pub_avg     = '0;
	logic [63:0]                   peak_usec   = '0;
	logic [63:0]                   low_usec    = '0;

	// Predicted status beats, oldest first.
	stats_t expected_stats [$];
	stats_t want_stats;

	// Stimulus bookkeeping.
	int          idle_pct     = 0;
	int          error_count  = 0;
	int          events_sent  = 0;
	int          results_seen = 0;
	int          match_count  = 0;
	int          tick_count   = 0;
	logic [62:0] wall_ns      = '0;
	logic [63:0] next_pts     = '0;
	logic [63:0] pts_history [$];

	frame_latency_bitrate_monitor_core #(
		.RING_DEPTH(RING_N)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.pts(pts),
		.now_ns(now_ns),
		.frame_bytes(frame_bytes),
		.done(done),
		.matched(matched),
		.bitrate_in(bitrate_in),
		.bitrate_out(bitrate_out),
		.lat_avg_us(lat_avg_us),
		.lat_max_us(lat_max_us),
		.lat_min_us(lat_min_us)
	);

	always #1 clk = ~clk;

	// Apply one event to the local state and return the status it publishes.
	function automatic stats_t predict_event(input logic [flbm_pkg::OPCODE_W-1:0] op,
			input logic [flbm_pkg::PTS_W-1:0] ev_pts, input logic [flbm_pkg::NS_W-1:0] ev_now,
			input logic [flbm_pkg::BYTES_W-1:0] ev_bytes);
		stats_t      r;
		logic [31:0] bits;
		logic [63:0] now64;
		logic [63:0] delay;
		logic [63:0] avg;
		int unsigned idx;
		bit          found;
		r     = '0;
		bits  = {ev_bytes, 3'b000};
		now64 = {1'b0, ev_now};
		case (op)
			flbm_pkg::OP_IN_FRAME: begin
				if (en_ring && en_lat) begin
					ring_pts[wr_ptr]   = ev_pts;
					ring_stamp[wr_ptr] = now64;
					wr_ptr             = (wr_ptr + 1) % RING_N;
				end
				if (en_bits)
					in_bits += bits;
			end
			flbm_pkg::OP_OUT_FRAME: begin
				if (en_bits)
					out_bits += bits;
			end
			flbm_pkg::OP_OUT_PTS: begin
				// Oldest-first search from the write pointer; only the first hit counts.
				found = 1'b0;
				idx   = wr_ptr;
				if ($signed(ev_pts) > 0) begin
					for (int k = 0; k < RING_N; k++) begin
						if (!found && ring_pts[idx] == ev_pts) begin
							found = 1'b1;
							if ($signed(now64) > $signed(ring_stamp[idx])) begin
								delay = now64 - ring_stamp[idx];
								if (delay > NSEC_MAX - lat_sum)
									lat_sum = NSEC_MAX;
								else
									lat_sum += delay;
								if (lat_cnt != '1)
									lat_cnt++;
								r.matched = 1'b1;
								match_count++;
							end
						end
						idx = (idx + 1) % RING_N;
					end
				end
			end
			default: begin
				tick_count++;
				if (en_bits) begin
					pub_in   = in_bits;
					pub_out  = out_bits;
					in_bits  = '0;
					out_bits = '0;
				end
				if (en_lat) begin
					avg = '0;
					if (lat_cnt != 0)
						avg = lat_sum / {32'd0, lat_cnt};
					avg     = avg / 1000;
					lat_sum = '0;
					lat_cnt = '0;
					pub_avg = avg;
					if (avg > peak_usec)
						peak_usec = avg;
					// A zero minimum is taken over by any average, zero included.
					if (low_usec == 0)
						low_usec = avg;
					if (avg > 0 && avg < low_usec)
						low_usec = avg;
				end
			end
		endcase
		r.bits_in  = pub_in;
		r.bits_out = pub_out;
		r.avg_usec = pub_avg[62:0];
		r.max_usec = peak_usec[62:0];
		r.min_usec = low_usec[62:0];
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly full-range sizes, some of them typical frame sizes.
	function automatic logic [flbm_pkg::BYTES_W-1:0] rand_bytes();
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(3) == 0)
			v = $urandom_range(200000, 0);
		return v[flbm_pkg::BYTES_W-1:0];
	endfunction

	// Send one event beat and record its prediction at the accepting edge.
	task automatic send_event(input logic [flbm_pkg::OPCODE_W-1:0] op,
			input logic [flbm_pkg::PTS_W-1:0] ev_pts, input logic [flbm_pkg::NS_W-1:0] ev_now,
			input logic [flbm_pkg::BYTES_W-1:0] ev_bytes);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(90, 1)) @(posedge clk);
		end
		start       <= 1'b1;
		opcode      <= op;
		pts         <= ev_pts;
		now_ns      <= ev_now;
		frame_bytes <= ev_bytes;
		do
			@(negedge clk);
		while (busy !== 1'b0);
		@(posedge clk);
		expected_stats.push_back(predict_event(op, ev_pts, ev_now, ev_bytes));
		events_sent++;
	endtask

	// Stop sending and let every outstanding beat come back.
	task automatic wait_idle();
		start <= 1'b0;
		while (expected_stats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all three enable registers back to back.
	task automatic set_enables(input bit br, input bit pr, input bit lat);
		cfg_we    <= 1'b1;
		cfg_index <= flbm_pkg::CFG_ENABLE_BITRATE;
		cfg_data  <= br;
		@(posedge clk);
		cfg_index <= flbm_pkg::CFG_ENABLE_PTS_REGISTER;
		cfg_data  <= pr;
		@(posedge clk);
		cfg_index <= flbm_pkg::CFG_ENABLE_LATENCY;
		cfg_data  <= lat;
		@(posedge clk);
		cfg_we  <= 1'b0;
		en_bits  = br;
		en_ring  = pr;
		en_lat   = lat;
	endtask

	// Reset outputs, a search of the empty ring, and a tick with no latency events.
	task automatic test_reset_values();
		send_event(flbm_pkg::OP_TICK, 64'd0, 63'd0, '0);
		send_event(flbm_pkg::OP_OUT_PTS, 64'd1, 63'd5, '0);
		wait_idle();
		set_enables(1'b1, 1'b1, 1'b1);
		send_event(flbm_pkg::OP_TICK, 64'd0, 63'd10, '0);
	endtask

	// Largest frame sizes, zero size and wrap of the input bit counter.
	task automatic test_bit_counting();
		send_event(flbm_pkg::OP_IN_FRAME, 64'd100, 63'd1000, '1);
		send_event(flbm_pkg::OP_IN_FRAME, 64'd100, 63'd3000, 29'd1);
		send_event(flbm_pkg::OP_OUT_FRAME, 64'd0, 63'd3100, '1);
		send_event(flbm_pkg::OP_OUT_FRAME, 64'd0, 63'd3200, '0);
	endtask

	// Oldest duplicate wins, zero and negative stamps, delay that is not positive.
	task automatic test_latency_match();
		send_event(flbm_pkg::OP_OUT_PTS, 64'd100, 63'd5000, '0);
		send_event(flbm_pkg::OP_OUT_PTS, 64'd0, 63'd5100, '0);
		send_event(flbm_pkg::OP_OUT_PTS, 64'h8000_0000_0000_0000, 63'd5200, '0);
		send_event(flbm_pkg::OP_OUT_PTS, 64'd100, 63'd500, '0);
		send_event(flbm_pkg::OP_TICK, 64'd0, 63'd6000, '0);
		send_event(flbm_pkg::OP_TICK, 64'd0, 63'd7000, '0);
	endtask

	// Saturation of the latency sum and a new smaller minimum.
	task automatic test_latency_extremes();
		send_event(flbm_pkg::OP_IN_FRAME, NSEC_MAX, 63'd0, '0);
		send_event(flbm_pkg::OP_OUT_PTS, NSEC_MAX, '1, '0);
		send_event(flbm_pkg::OP_OUT_PTS, NSEC_MAX, '1, '0);
		send_event(flbm_pkg::OP_TICK, '1, '1, '1);
		send_event(flbm_pkg::OP_IN_FRAME, 64'd50, 63'd0, 29'd7);
		send_event(flbm_pkg::OP_OUT_PTS, 64'd50, 63'd2500, '0);
		send_event(flbm_pkg::OP_TICK, 64'd0, 63'd2600, '0);
	endtask

	// Disabled statistics are neither published nor cleared at a tick.
	task automatic test_disabled_stats();
		wait_idle();
		set_enables(1'b0, 1'b1, 1'b0);
		send_event(flbm_pkg::OP_IN_FRAME, 64'd7, 63'd10, 29'd3);
		send_event(flbm_pkg::OP_OUT_PTS, 64'd50, 63'd10000, '0);
		send_event(flbm_pkg::OP_TICK, 64'd0, 63'd10100, '0);
		wait_idle();
		set_enables(1'b1, 1'b0, 1'b1);
		send_event(flbm_pkg::OP_IN_FRAME, 64'd9, 63'd10, 29'd5);
		send_event(flbm_pkg::OP_OUT_PTS, 64'd9, 63'd50, '0);
		send_event(flbm_pkg::OP_TICK, 64'd0, 63'd60, '0);
	endtask

	// Frame traffic with matching timestamps, mixed with ticks and noise.
	task automatic test_random_traffic(input int count, input int pct);
		int          sel;
		logic [63:0] p;
		logic [63:0] t;
		idle_pct = pct;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(99);
			if ($urandom_range(49) == 0) begin
				t       = rand64();
				wall_ns = t[62:0];
			end else begin
				wall_ns += 63'($urandom_range(200000, 1));
			end
			if (sel < 35) begin
				if (pts_history.size() != 0 && $urandom_range(6) == 0) begin
					p = pts_history[$urandom_range(pts_history.size() - 1)];
				end else begin
					next_pts += 64'($urandom_range(4, 1));
					p = next_pts;
				end
				pts_history.push_back(p);
				if (pts_history.size() > 20)
					void'(pts_history.pop_front());
				send_event(flbm_pkg::OP_IN_FRAME, p, wall_ns, rand_bytes());
			end else if (sel < 55) begin
				send_event(flbm_pkg::OP_OUT_FRAME, rand64(), wall_ns, rand_bytes());
			end else if (sel < 80) begin
				if (pts_history.size() != 0 && $urandom_range(4) != 0)
					p = pts_history[$urandom_range(pts_history.size() - 1)];
				else if ($urandom_range(3) == 0)
					p = '0;
				else
					p = rand64();
				send_event(flbm_pkg::OP_OUT_PTS, p, wall_ns, rand_bytes());
			end else if (sel < 90) begin
				send_event(flbm_pkg::OP_TICK, rand64(), wall_ns, rand_bytes());
			end else begin
				t = rand64();
				send_event(flbm_pkg::OPCODE_W'($urandom_range(3)), rand64(), t[62:0],
					rand_bytes());
			end
		end
		idle_pct = 0;
	endtask

	// Compare each done beat with the oldest prediction.
	always @(negedge clk) begin
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (expected_stats.size() == 0) begin
				$error("done strobe with no event outstanding");
				error_count++;
			end else begin
				want_stats = expected_stats.pop_front();
				if (matched !== want_stats.matched) begin
					$error("matched: expected %0d, got %0d", want_stats.matched, matched);
					error_count++;
				end
				if (bitrate_in !== want_stats.bits_in) begin
					$error("bitrate_in: expected %0d, got %0d", want_stats.bits_in, bitrate_in);
					error_count++;
				end
				if (bitrate_out !== want_stats.bits_out) begin
					$error("bitrate_out: expected %0d, got %0d", want_stats.bits_out,
						bitrate_out);
					error_count++;
				end
				if (lat_avg_us !== want_stats.avg_usec) begin
					$error("lat_avg_us: expected %0d, got %0d", want_stats.avg_usec,
						lat_avg_us);
					error_count++;
				end
				if (lat_max_us !== want_stats.max_usec) begin
					$error("lat_max_us: expected %0d, got %0d", want_stats.max_usec,
						lat_max_us);
					error_count++;
				end
				if (lat_min_us !== want_stats.min_usec) begin
					$error("lat_min_us: expected %0d, got %0d", want_stats.min_usec,
						lat_min_us);
					error_count++;
				end
			end
		end
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		bit [2:0] phase_cfg [8];
		int       pct_cycle [4];
		bit [2:0] c;
		phase_cfg = '{3'b111, 3'b000, 3'b111, 3'b011, 3'b101, 3'b110, 3'b111, 3'b111};
		pct_cycle = '{0, 55, 0, 29};
		next_pts  = rand64() >> 2;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_bit_counting();
		test_latency_match();
		test_latency_extremes();
		test_disabled_stats();

		// Random phases, each under its own enable setting and idle rate.
		for (int ph = 0; ph < 8; ph++) begin
			c = (ph == 6) ? 3'($urandom_range(7)) : phase_cfg[ph];
			wait_idle();
			set_enables(c[2], c[1], c[0]);
			test_random_traffic(190, pct_cycle[ph % 4]);
		end

		start <= 1'b0;
		for (int w = 0; w < 5000 && expected_stats.size() != 0; w++)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (expected_stats.size() != 0) begin
			$error("%0d predicted beats never came back", expected_stats.size());
			error_count++;
		end

		$display("summary: %0d events sent, %0d results checked, %0d errors",
			events_sent, results_seen, error_count);
		$display("summary: %0d timestamp matches and %0d period ticks under varied enables",
			match_count, tick_count);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
